// ===== sv/baos_pkg.sv =====
// shared types and codes for the bipartite box overlap search unit
package baos_pkg;

   // operation codes carried in the func field
   localparam logic [1:0] FUNC_LOAD_MASTER = 2'd0;
   localparam logic [1:0] FUNC_LOAD_SLAVE  = 2'd1;
   localparam logic [1:0] FUNC_QUERY       = 2'd2;

   // register select, taken from address bit 2
   localparam logic CSR_MASTER_COUNT   = 1'b0;
   localparam logic CSR_SEARCH_PADDING = 1'b1;

   typedef struct packed {
      logic [1:0]         func;
      logic [5:0]         entity_index;
      logic signed [31:0] x_low;
      logic signed [31:0] x_high;
      logic signed [31:0] y_low;
      logic signed [31:0] y_high;
      logic signed [31:0] z_low;
      logic signed [31:0] z_high;
   } req_type;

   typedef struct packed {
      logic [5:0] master_index;
      logic       found;
      logic       last_of_run;
   } rsp_type;

endpackage

// ===== sv/baos_ram.sv =====
// generic simple dual-port ram with registered read
module baos_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 64,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bipartite_aabb_overlap_search_unit.sv =====
// top level of the bipartite box overlap search unit
//
// usage
// - req channel carries one item per handshake: load a master box, load a slave box,
//   or query a slave. loads widen the box by search_padding (saturating) and write it
//   into the master or slave box ram in the cycle the item is accepted
// - a query reads the slave box once, then walks masters 0 .. master_count-1 (capped at
//   MAX_MASTERS) through the master box ram, one master per cycle unless a hit waits on
//   a stalled rsp, and sends every overlapping master on the rsp channel; last_of_run
//   marks the final item, a lone not-found item is sent when nothing overlaps
// - a load leaves req_stall low, so the next item is taken right after; a query holds
//   req_stall high while it walks, paced by the single read port of the master box ram;
//   its final item is valid in the first cycle req_stall is low again
// - each hit is held back one slot so the last one can carry last_of_run; with rsp
//   stalled the walk runs on through misses and waits at a hit while both the held
//   slot and the output register are full, no item is dropped
// - the rsp output register lets a new item be accepted while a result still waits
// - reset clears control state and both registers; box rams are not cleared, and a
//   query that touches a box never loaded returns undefined fields
// - registers: master_count at byte 0, search_padding at byte 4 (apb, no wait states)
module bipartite_aabb_overlap_search_unit #(
   parameter int MAX_MASTERS = 64,
   parameter int MAX_SLAVES  = 64,
   parameter int COORD_BITS  = 32
) (
   input  logic              clock,
   input  logic              reset,
   // item input
   input  logic              req_valid,
   output logic              req_stall,
   input  baos_pkg::req_type req_data,
   // result output
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output baos_pkg::rsp_type rsp_data,
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   import baos_pkg::*;

   // address widths of the two box rams
   localparam int MAW = (MAX_MASTERS > 1) ? $clog2(MAX_MASTERS) : 1;
   localparam int SAW = (MAX_SLAVES > 1) ? $clog2(MAX_SLAVES) : 1;
   // one ram word holds all six bounds of a box
   localparam int BOX_BITS = 6 * COORD_BITS;
   // padding arithmetic width: 32-bit bound plus 31-bit pad needs 33 bits, 34 are used
   localparam int EXT = (COORD_BITS > 34) ? COORD_BITS : 34;

   localparam logic signed [EXT-1:0] COORD_MAX_EXT =
      {{(EXT - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
   localparam logic signed [EXT-1:0] COORD_MIN_EXT = ~COORD_MAX_EXT;

   localparam logic [6:0]  MASTER_LIMIT = 7'(MAX_MASTERS);
   localparam logic [31:0] SLAVE_LIMIT  = 32'(MAX_SLAVES);

   // controller states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // widen one bound by the padding, saturate to the coordinate range
   function automatic logic [COORD_BITS-1:0] pad_bound(input logic [31:0] v,
                                                       input logic [30:0] pad,
                                                       input logic        up);
      logic signed [EXT-1:0]  base;
      logic signed [EXT-1:0]  amount;
      logic signed [EXT-1:0]  sum;
      logic [COORD_BITS-1:0]  res;
      base   = EXT'($signed(v));
      amount = EXT'(pad);
      sum    = up ? (base + amount) : (base - amount);
      if (sum > COORD_MAX_EXT) begin
         res = COORD_MAX_EXT[COORD_BITS-1:0];
      end else if (sum < COORD_MIN_EXT) begin
         res = COORD_MIN_EXT[COORD_BITS-1:0];
      end else begin
         res = sum[COORD_BITS-1:0];
      end
      return res;
   endfunction

   // registers
   logic [6:0]  master_count_ff, master_count_in;
   logic [30:0] search_padding_ff, search_padding_in;

   // control
   logic [1:0]  state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        cmp_valid_ff, cmp_valid_in;
   logic [5:0]  cmp_idx_ff, cmp_idx_in;
   logic        held_valid_ff, held_valid_in;
   logic [5:0]  held_idx_ff, held_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic                req_accept;
   logic                csr_write;
   logic [6:0]          limit;
   logic                master_in_range;
   logic                slave_in_range;
   logic [BOX_BITS-1:0] box_in;
   logic                master_wr_en;
   logic                slave_wr_en;
   logic                slave_rd_en;
   logic                master_rd_en;
   logic [BOX_BITS-1:0] master_box;
   logic [BOX_BITS-1:0] slave_box;
   logic                hit;
   logic                out_free;
   logic                more;
   logic                consume;
   logic                rsp_load;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // register port, writes and reads decoded on address bit 2
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      master_count_in   = master_count_ff;
      search_padding_in = search_padding_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_MASTER_COUNT:   master_count_in   = csr_pwdata[6:0];
            CSR_SEARCH_PADDING: search_padding_in = csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_MASTER_COUNT:   csr_prdata = {25'd0, master_count_ff};
         CSR_SEARCH_PADDING: csr_prdata = {1'b0, search_padding_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // masters actually walked per query
   assign limit = (master_count_ff > MASTER_LIMIT) ? MASTER_LIMIT : master_count_ff;

   assign master_in_range = (32'(req_data.entity_index) < 32'(MAX_MASTERS));
   assign slave_in_range  = (32'(req_data.entity_index) < SLAVE_LIMIT);

   // padded box, bound slots x_low, x_high, y_low, y_high, z_low, z_high
   assign box_in[0*COORD_BITS +: COORD_BITS] =
      pad_bound(req_data.x_low, search_padding_ff, 1'b0);
   assign box_in[1*COORD_BITS +: COORD_BITS] =
      pad_bound(req_data.x_high, search_padding_ff, 1'b1);
   assign box_in[2*COORD_BITS +: COORD_BITS] =
      pad_bound(req_data.y_low, search_padding_ff, 1'b0);
   assign box_in[3*COORD_BITS +: COORD_BITS] =
      pad_bound(req_data.y_high, search_padding_ff, 1'b1);
   assign box_in[4*COORD_BITS +: COORD_BITS] =
      pad_bound(req_data.z_low, search_padding_ff, 1'b0);
   assign box_in[5*COORD_BITS +: COORD_BITS] =
      pad_bound(req_data.z_high, search_padding_ff, 1'b1);

   assign master_wr_en = req_accept && (req_data.func == FUNC_LOAD_MASTER) && master_in_range;
   assign slave_wr_en  = req_accept && (req_data.func == FUNC_LOAD_SLAVE) && slave_in_range;

   // the slave box is read once at query accept; its read data holds for the whole walk
   assign slave_rd_en = req_accept && (req_data.func == FUNC_QUERY) && slave_in_range
                        && (limit != 7'd0);

   baos_ram #(
      .WIDTH (BOX_BITS),
      .DEPTH (MAX_MASTERS)
   ) u_master_ram (
      .clock   (clock),
      .wr_en   (master_wr_en),
      .wr_addr (MAW'(req_data.entity_index)),
      .wr_data (box_in),
      .rd_en   (master_rd_en),
      .rd_addr (cnt_ff[MAW-1:0]),
      .rd_data (master_box)
   );

   baos_ram #(
      .WIDTH (BOX_BITS),
      .DEPTH (MAX_SLAVES)
   ) u_slave_ram (
      .clock   (clock),
      .wr_en   (slave_wr_en),
      .wr_addr (SAW'(req_data.entity_index)),
      .wr_data (box_in),
      .rd_en   (slave_rd_en),
      .rd_addr (SAW'(req_data.entity_index)),
      .rd_data (slave_box)
   );

   // closed-interval overlap on all three axes
   always_comb begin
      logic signed [COORD_BITS-1:0] m_lo;
      logic signed [COORD_BITS-1:0] m_hi;
      logic signed [COORD_BITS-1:0] s_lo;
      logic signed [COORD_BITS-1:0] s_hi;
      hit = 1'b1;
      for (int k = 0; k < 3; k++) begin
         m_lo = master_box[(2*k)*COORD_BITS +: COORD_BITS];
         m_hi = master_box[(2*k+1)*COORD_BITS +: COORD_BITS];
         s_lo = slave_box[(2*k)*COORD_BITS +: COORD_BITS];
         s_hi = slave_box[(2*k+1)*COORD_BITS +: COORD_BITS];
         if ((m_lo > s_hi) || (s_lo > m_hi)) begin
            hit = 1'b0;
         end
      end
   end

   // walk pipeline: read issue, then compare on the ram output
   // a hit only moves on when the held hit can go to the output register
   assign more    = (cnt_ff < limit);
   assign consume = (state_ff == ST_SCAN) && cmp_valid_ff
                    && (!hit || !held_valid_ff || out_free);
   assign master_rd_en = (state_ff == ST_SCAN) && more && (!cmp_valid_ff || consume);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_idx_in    = cmp_idx_ff;
      held_valid_in = held_valid_ff;
      held_idx_in   = held_idx_ff;
      rsp_load      = 1'b0;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.func == FUNC_QUERY)) begin
               held_valid_in = 1'b0;
               cnt_in        = 7'd0;
               // empty walk or bad slave index goes straight to not-found
               state_in      = slave_rd_en ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (master_rd_en) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = cnt_ff[5:0];
               cnt_in       = cnt_ff + 7'd1;
            end else if (consume) begin
               cmp_valid_in = 1'b0;
            end
            if (consume && hit) begin
               // previous hit is known not to be the last one
               if (held_valid_ff) begin
                  rsp_load                 = 1'b1;
                  rsp_data_in.master_index = held_idx_ff;
                  rsp_data_in.found        = 1'b1;
                  rsp_data_in.last_of_run  = 1'b0;
               end
               held_valid_in = 1'b1;
               held_idx_in   = cmp_idx_ff;
            end
            if (!more && (!cmp_valid_ff || consume)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_load                 = 1'b1;
               rsp_data_in.master_index = held_valid_ff ? held_idx_ff : 6'd0;
               rsp_data_in.found        = held_valid_ff;
               rsp_data_in.last_of_run  = 1'b1;
               held_valid_in            = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         master_count_ff   <= 7'd0;
         search_padding_ff <= 31'd0;
         state_ff          <= ST_IDLE;
         cnt_ff            <= 7'd0;
         cmp_valid_ff      <= 1'b0;
         held_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         master_count_ff   <= master_count_in;
         search_padding_ff <= search_padding_in;
         state_ff          <= state_in;
         cnt_ff            <= cnt_in;
         cmp_valid_ff      <= cmp_valid_in;
         held_valid_ff     <= held_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      held_idx_ff <= held_idx_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/tb_bipartite_aabb_overlap_search_unit.sv =====
// self-checking testbench for the bipartite box overlap search unit
module tb_bipartite_aabb_overlap_search_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import baos_pkg::*;

   localparam int NUM_MASTERS   = 64;
   localparam int NUM_SLAVES    = 64;
   // a query walks at most 64 masters plus the read and compare pipeline
   localparam int SETTLE_CYCLES = 80;
   // cycles without any handshake before the run is declared hung
   localparam int QUIET_LIMIT   = 4000;

   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
   // one unit in signed q16.16
   localparam logic signed [31:0] UNIT      = 32'sh0001_0000;
   localparam logic [30:0]        PAD_MAX   = 31'h7FFF_FFFF;
   // func code that the block ignores
   localparam logic [1:0]         FUNC_UNUSED = 2'd3;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state: padded boxes as stored, and which entries hold a box
   logic signed [31:0] master_bounds [NUM_MASTERS][6];
   logic signed [31:0] slave_bounds  [NUM_SLAVES][6];
   bit                 master_loaded [NUM_MASTERS];
   bit                 slave_loaded  [NUM_SLAVES];
   logic [6:0]         cfg_master_count = '0;
   logic [30:0]        cfg_padding      = '0;

   // overlapping masters still to come out, oldest first
   rsp_type expected_matches [$];
   rsp_type oldest_match;

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   // idling rates in percent of cycles
   int send_idle_pct  = 36;
   int recv_stall_pct = 54;

   bipartite_aabb_overlap_search_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // widen one bound by the padding, saturating to the 32-bit signed range
   function automatic logic signed [31:0] pad_bound(input logic signed [31:0] bound,
                                                    input bit upper);
      longint sum;
      if (upper)
         sum = longint'(bound) + longint'(cfg_padding);
      else
         sum = longint'(bound) - longint'(cfg_padding);
      if (sum > longint'(COORD_MAX))
         return COORD_MAX;
      if (sum < longint'(COORD_MIN))
         return COORD_MIN;
      return sum[31:0];
   endfunction

   // update the box stores for a load, or queue the matches of a query
   task automatic predict_search(input req_type item);
      logic signed [31:0] given [6];
      logic signed [31:0] padded [6];
      bit      overlaps [NUM_MASTERS];
      int      limit;
      int      last_hit;
      bit      hit;
      rsp_type result;
      given = '{item.x_low, item.x_high, item.y_low, item.y_high, item.z_low, item.z_high};
      for (int k = 0; k < 6; k++)
         padded[k] = pad_bound(given[k], k % 2 == 1);
      case (item.func)
         FUNC_LOAD_MASTER: begin
            for (int k = 0; k < 6; k++)
               master_bounds[item.entity_index][k] = padded[k];
            master_loaded[item.entity_index] = 1'b1;
         end
         FUNC_LOAD_SLAVE: begin
            for (int k = 0; k < 6; k++)
               slave_bounds[item.entity_index][k] = padded[k];
            slave_loaded[item.entity_index] = 1'b1;
         end
         FUNC_QUERY: begin
            // counts above the store size search the whole store
            limit = (cfg_master_count > NUM_MASTERS) ? NUM_MASTERS : cfg_master_count;
            last_hit = -1;
            for (int m = 0; m < limit; m++) begin
               hit = 1'b1;
               // closed intervals: touching boxes overlap
               for (int a = 0; a < 3; a++)
                  if (master_bounds[m][2*a] > slave_bounds[item.entity_index][2*a+1] ||
                      slave_bounds[item.entity_index][2*a] > master_bounds[m][2*a+1])
                     hit = 1'b0;
               overlaps[m] = hit;
               if (hit)
                  last_hit = m;
            end
            if (last_hit < 0) begin
               // nothing overlaps: one lone not-found item
               result.master_index = '0;
               result.found        = 1'b0;
               result.last_of_run  = 1'b1;
               expected_matches = {expected_matches, result};
            end else begin
               for (int m = 0; m <= last_hit; m++)
                  if (overlaps[m]) begin
                     result.master_index = m[5:0];
                     result.found        = 1'b1;
                     result.last_of_run  = (m == last_hit);
                     expected_matches = {expected_matches, result};
                  end
            end
         end
         default: ;  // unused code, no effect
      endcase
   endtask

   // ------------------------------------------------------------------
   // item building
   // ------------------------------------------------------------------

   function automatic req_type make_box_item(input logic [1:0] func, input logic [5:0] index,
                                             input logic signed [31:0] x_low, x_high,
                                             input logic signed [31:0] y_low, y_high,
                                             input logic signed [31:0] z_low, z_high);
      req_type item;
      item = '{func, index, x_low, x_high, y_low, y_high, z_low, z_high};
      return item;
   endfunction

   // same interval on all three axes
   function automatic req_type cube_item(input logic [1:0] func, input logic [5:0] index,
                                         input logic signed [31:0] low, high);
      return make_box_item(func, index, low, high, low, high, low, high);
   endfunction

   // random box: mostly small boxes near the origin so that overlaps are common,
   // some with fully random bounds, some pinned near the range limits
   function automatic req_type random_load(input logic [1:0] func, input logic [5:0] index);
      logic signed [31:0] b [6];
      logic signed [31:0] center;
      logic signed [31:0] extent;
      logic signed [31:0] swap;
      int style;
      style = $urandom_range(99);
      for (int a = 0; a < 3; a++) begin
         if (style < 60) begin
            center = int'($urandom_range(16 * 65536)) - 8 * 65536;
            extent = $urandom_range(8 * 65536);
            b[2*a]   = center - extent;
            b[2*a+1] = center + extent;
            // now and then an inverted box
            if ($urandom_range(9) == 0) begin
               swap     = b[2*a];
               b[2*a]   = b[2*a+1];
               b[2*a+1] = swap;
            end
         end else if (style < 80) begin
            b[2*a]   = $urandom;
            b[2*a+1] = $urandom;
         end else begin
            for (int k = 0; k < 2; k++)
               case ($urandom_range(4))
                  0: b[2*a+k] = COORD_MIN;
                  1: b[2*a+k] = COORD_MAX;
                  2: b[2*a+k] = COORD_MIN + 32'($urandom_range(255));
                  3: b[2*a+k] = COORD_MAX - 32'($urandom_range(255));
                  default: b[2*a+k] = int'($urandom_range(255)) - 128;
               endcase
         end
      end
      return make_box_item(func, index, b[0], b[1], b[2], b[3], b[4], b[5]);
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // offer one item, with random idle cycles ahead of it, and predict on acceptance
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_search(item);
   endtask

   // drop valid, wait for every expected item, then let a query with no
   // pending output run out before touching the registers
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_matches.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic regsel, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {regsel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (regsel == CSR_MASTER_COUNT)
         cfg_master_count = value[6:0];
      else
         cfg_padding = value[30:0];
      // bus goes idle between transfers
      @(posedge clock);
   endtask

   task automatic csr_check_read(input logic regsel, input logic [31:0] expected);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {regsel, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== expected) begin
         $display("%0t: register %0d read expected %h actual %h",
                  $time, regsel, expected, csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // result side: random stalls, checking, hang detection
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // every accepted result is matched against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_matches.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual index %0d found %0b last %0b",
                     $time, rsp_data.master_index, rsp_data.found, rsp_data.last_of_run);
            mismatch_count++;
         end else begin
            oldest_match = expected_matches.pop_front();
            if (rsp_data.master_index !== oldest_match.master_index) begin
               $display("%0t: master_index expected %0d actual %0d",
                        $time, oldest_match.master_index, rsp_data.master_index);
               mismatch_count++;
            end
            if (rsp_data.found !== oldest_match.found) begin
               $display("%0t: found expected %0b actual %0b",
                        $time, oldest_match.found, rsp_data.found);
               mismatch_count++;
            end
            if (rsp_data.last_of_run !== oldest_match.last_of_run) begin
               $display("%0t: last_of_run expected %0b actual %0b",
                        $time, oldest_match.last_of_run, rsp_data.last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   // any handshake or register access counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
         $display("tb_bipartite_aabb_overlap_search_unit NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset values, readback at the register widths, then back to zero
   task automatic test_register_access();
      csr_check_read(CSR_MASTER_COUNT, 32'd0);
      csr_check_read(CSR_SEARCH_PADDING, 32'd0);
      csr_write(CSR_MASTER_COUNT, 32'd127);
      csr_write(CSR_SEARCH_PADDING, {1'b0, PAD_MAX});
      csr_check_read(CSR_MASTER_COUNT, 32'd127);
      csr_check_read(CSR_SEARCH_PADDING, {1'b0, PAD_MAX});
      csr_write(CSR_MASTER_COUNT, 32'd0);
      csr_write(CSR_SEARCH_PADDING, 32'd0);
   endtask

   // zero master count gives a lone not-found, the unused func code is ignored
   task automatic test_empty_search();
      send_item(cube_item(FUNC_LOAD_SLAVE, 6'd0, 0, 10 * UNIT));
      send_item(make_box_item(FUNC_UNUSED, 6'd63, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom));
      send_item(cube_item(FUNC_QUERY, 6'd0, 0, 0));
   endtask

   // closed intervals, inverted boxes, full-range boxes, no overlap at all
   task automatic test_overlap_rules();
      wait_until_idle();
      csr_write(CSR_MASTER_COUNT, 32'd4);
      send_item(cube_item(FUNC_LOAD_SLAVE, 6'd5, 0, 10 * UNIT));
      // touches the slave on the x face
      send_item(make_box_item(FUNC_LOAD_MASTER, 6'd0, 10 * UNIT, 20 * UNIT,
                              0, 10 * UNIT, 0, 10 * UNIT));
      // one lsb clear of the slave on z
      send_item(make_box_item(FUNC_LOAD_MASTER, 6'd1, 0, 10 * UNIT,
                              0, 10 * UNIT, 10 * UNIT + 1, 20 * UNIT));
      // inverted on x, still passes both tests of the overlap rule
      send_item(make_box_item(FUNC_LOAD_MASTER, 6'd2, 5 * UNIT, 3 * UNIT,
                              2 * UNIT, 4 * UNIT, 2 * UNIT, 4 * UNIT));
      send_item(cube_item(FUNC_LOAD_MASTER, 6'd3, COORD_MIN, COORD_MAX));
      // fully inverted extreme slave, only the full-range master reaches it
      send_item(cube_item(FUNC_LOAD_SLAVE, 6'd6, COORD_MAX, COORD_MIN));
      send_item(cube_item(FUNC_LOAD_SLAVE, 6'd7, 100 * UNIT, 200 * UNIT));
      send_item(cube_item(FUNC_QUERY, 6'd5, 0, 0));
      send_item(cube_item(FUNC_QUERY, 6'd6, 0, 0));
      send_item(cube_item(FUNC_QUERY, 6'd7, 0, 0));
      // without the full-range master both far slaves find nothing
      wait_until_idle();
      csr_write(CSR_MASTER_COUNT, 32'd3);
      send_item(cube_item(FUNC_QUERY, 6'd7, 0, 0));
      send_item(cube_item(FUNC_QUERY, 6'd6, 0, 0));
   endtask

   // largest padding: bounds saturate at both ends, one lands exactly on the limit
   task automatic test_padding_saturation();
      wait_until_idle();
      csr_write(CSR_SEARCH_PADDING, {1'b0, PAD_MAX});
      csr_write(CSR_MASTER_COUNT, 32'd5);
      send_item(make_box_item(FUNC_LOAD_MASTER, 6'd4, COORD_MIN + 5, COORD_MAX - 5,
                              0, 0, -1, 1));
      send_item(cube_item(FUNC_LOAD_SLAVE, 6'd8, COORD_MAX, COORD_MAX));
      send_item(cube_item(FUNC_QUERY, 6'd8, 0, 0));
      send_item(cube_item(FUNC_QUERY, 6'd5, 0, 0));
   endtask

   // one register setting, the masters it searches loaded first, then random items
   task automatic run_phase(input logic [6:0] count, input logic [30:0] padding,
                            input int items);
      int pick;
      int index;
      int limit;
      wait_until_idle();
      csr_write(CSR_MASTER_COUNT, {25'd0, count});
      csr_write(CSR_SEARCH_PADDING, {1'b0, padding});
      limit = (count > NUM_MASTERS) ? NUM_MASTERS : count;
      // a query never reads a master box that was never loaded
      for (int m = 0; m < limit; m++)
         if (!master_loaded[m])
            send_item(random_load(FUNC_LOAD_MASTER, m[5:0]));
      for (int n = 0; n < items; n++) begin
         pick  = $urandom_range(99);
         index = $urandom_range(NUM_SLAVES - 1);
         if (pick < 25)
            send_item(random_load(FUNC_LOAD_MASTER, index[5:0]));
         else if (pick < 45 || !slave_loaded[index])
            // a query for an empty slave entry becomes a load of it
            send_item(random_load(FUNC_LOAD_SLAVE, index[5:0]));
         else if (pick < 50)
            send_item(make_box_item(FUNC_UNUSED, index[5:0], $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom));
         else
            send_item(make_box_item(FUNC_QUERY, index[5:0], $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom));
      end
   endtask

   // several settings with the extremes, under each idling pattern in turn
   task automatic test_random_traffic();
      send_idle_pct  = 36;
      recv_stall_pct = 54;
      run_phase(7'd4, 31'd0, 22);
      run_phase(7'd127, 31'($urandom_range(32'h4_0000)), 22);
      send_idle_pct  = 54;
      recv_stall_pct = 36;
      run_phase(7'd64, PAD_MAX, 22);
      run_phase(7'($urandom_range(12, 1)), 31'($urandom_range(32'h2_0000)), 22);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_phase(7'd2, 31'h1_0000, 22);
      run_phase(7'd64, 31'd0, 22);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_empty_search();
      test_overlap_rules();
      test_padding_saturation();
      test_random_traffic();
      // drain the last results, then allow the block to settle
      wait_until_idle();
      if (mismatch_count == 0 && expected_matches.size() == 0)
         $display("tb_bipartite_aabb_overlap_search_unit OK");
      else
         $display("tb_bipartite_aabb_overlap_search_unit NOT OK");
      $finish;
   end

endmodule
